@@ hw/rtl/ipdfr_pkg.sv @@
// Shared types and constants for the IP stream packet deframer.
// No dependencies; every other file of the block imports this package.
package ipdfr_pkg;

    localparam int POS_W = 17;

    // Byte positions inside a packet at which header fields are picked up.
    localparam logic [POS_W-1:0] POS_V4_LEN_HI   = 17'd2;
    localparam logic [POS_W-1:0] POS_V4_LEN_LO   = 17'd3;
    localparam logic [POS_W-1:0] POS_BAD_VERSION = 17'd3;
    localparam logic [POS_W-1:0] POS_V6_LEN_HI   = 17'd4;
    localparam logic [POS_W-1:0] POS_V6_LEN_LO   = 17'd5;
    localparam logic [POS_W-1:0] POS_V4_CHECK    = 17'd19;

    localparam logic [3:0] VERSION_4 = 4'd4;
    localparam logic [3:0] VERSION_6 = 4'd6;

    localparam logic [5:0]       IPV4_MIN_HEADER = 6'd20;
    localparam logic [POS_W-1:0] IPV6_HEADER     = 17'd40;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       ipv6;
        logic       abort;
    } t_result;

endpackage

@@ hw/rtl/ipdfr_parse.sv @@
// Per-packet header tracking: byte position, length fields, version and halt state.
// Depends on ipdfr_pkg. Produces the tagged result for one byte each time it is stepped.
module ipdfr_parse
    import ipdfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_len, n_len;
    logic             r_known, n_known;
    logic             r_v6, n_v6;
    logic             r_bad, n_bad;
    logic [3:0]       r_hw, n_hw;
    logic [7:0]       r_len_hi, n_len_hi;
    logic             r_halted, n_halted;

    logic             first;
    logic             err;
    logic             last;
    logic [5:0]       hdr_bytes;
    logic [POS_W:0]   pos_inc;

    always_comb begin
        first     = (r_pos == '0);
        n_v6      = r_v6;
        n_bad     = r_bad;
        n_hw      = r_hw;
        n_known   = r_known;
        n_len     = r_len;
        n_len_hi  = r_len_hi;
        err       = 1'b0;

        // The first byte sets the version for the whole packet, itself included.
        if (first) begin
            n_v6    = (i_byte[7:4] == VERSION_6);
            n_bad   = (i_byte[7:4] != VERSION_4) && (i_byte[7:4] != VERSION_6);
            n_hw    = i_byte[3:0];
            n_known = 1'b0;
            n_len   = '0;
        end

        hdr_bytes = {n_hw, 2'b00};

        if (n_bad) begin
            err = (r_pos == POS_BAD_VERSION);
        end else if (!n_v6) begin
            if (r_pos == POS_V4_LEN_HI) begin
                n_len_hi = i_byte;
            end else if (r_pos == POS_V4_LEN_LO) begin
                n_len = {1'b0, r_len_hi, i_byte};
            end else if (r_pos == POS_V4_CHECK) begin
                if ((hdr_bytes < IPV4_MIN_HEADER)
                        || (n_len < {{(POS_W-6){1'b0}}, hdr_bytes})) begin
                    err = 1'b1;
                end else begin
                    n_known = 1'b1;
                end
            end
        end else begin
            if (r_pos == POS_V6_LEN_HI) begin
                n_len_hi = i_byte;
            end else if (r_pos == POS_V6_LEN_LO) begin
                n_len   = IPV6_HEADER + {1'b0, r_len_hi, i_byte};
                n_known = 1'b1;
            end
        end

        pos_inc = {1'b0, r_pos} + 18'd1;
        last    = !err && n_known && (pos_inc == {1'b0, n_len});

        if (last) begin
            n_pos   = '0;
            n_known = 1'b0;
        end else begin
            n_pos = pos_inc[POS_W-1:0];
        end

        n_halted = r_halted || err;

        o_res_valid = !r_halted;
        o_res.data  = i_byte;
        o_res.first = first;
        o_res.last  = last;
        o_res.ipv6  = n_v6;
        o_res.abort = err;
    end

    // Once halted the state freezes, so later bytes are simply dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_known  <= 1'b0;
            r_v6     <= 1'b0;
            r_bad    <= 1'b0;
            r_hw     <= '0;
            r_len_hi <= '0;
            r_halted <= 1'b0;
        end else if (i_step && !r_halted) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_known  <= n_known;
            r_v6     <= n_v6;
            r_bad    <= n_bad;
            r_hw     <= n_hw;
            r_len_hi <= n_len_hi;
            r_halted <= n_halted;
        end
    end

endmodule

@@ hw/rtl/ipdfr_out_stage.sv @@
// Output register holding one tagged byte until the receiver takes it.
// Depends on ipdfr_pkg for the result type.
module ipdfr_out_stage
    import ipdfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_free,
    output logic    o_out_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // The register can take a new result in the same cycle the old one leaves.
    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ hw/rtl/ip_stream_packet_deframer_unit.sv @@
// IP stream packet deframer: usage notes
// The input channel (i_in_valid / o_in_ready / i_in_byte) takes one byte of a raw stream
// of back-to-back IPv4 and IPv6 packets per transfer. The output channel (o_out_valid /
// i_out_ready) returns each byte unchanged, tagged with first-of-packet, last-of-packet
// (from the header length field), IPv6 and abort flags.
// A byte accepted sits in the input register, is parsed there by combinational logic
// and is loaded into the output register once that is free. While the receiver is ready,
// one byte per cycle is sustained; the parse step is a single pass of short logic.
// A malformed header (unknown version, found at packet byte 3, or a bad IPv4 header or
// total length, found at byte 19) is reported once with the abort flag; after that
// every byte is still accepted but dropped, and nothing more leaves until reset.
// While the receiver stalls, the output register holds its byte, the input register
// fills, and o_in_ready falls; no byte is lost. Synchronous active-low reset clears the
// parser to the start of a packet and empties both registers.
// Depends on ipdfr_pkg, ipdfr_parse and ipdfr_out_stage.
module ip_stream_packet_deframer_unit
    import ipdfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_first_of_packet,
    output logic       o_last_of_packet,
    output logic       o_is_ipv6,
    output logic       o_abort_error
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic    res_valid;
    t_result res;
    logic    out_free;
    logic    advance;
    t_result out_res;

    // A byte with no result (stream halted) leaves the input register regardless of stalls.
    assign advance    = r_in_valid && (out_free || !res_valid);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    ipdfr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ipdfr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_out_byte        = out_res.data;
    assign o_first_of_packet = out_res.first;
    assign o_last_of_packet  = out_res.last;
    assign o_is_ipv6         = out_res.ipv6;
    assign o_abort_error     = out_res.abort;

endmodule
